/* design/timer_table_one_shot_periodic_core_defines.svh */
// Assertion macros for the timer table core.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef TIMER_TABLE_ONE_SHOT_PERIODIC_CORE_DEFINES_SVH
`define TIMER_TABLE_ONE_SHOT_PERIODIC_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TTOSP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TTOSP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ttosp_pkg.sv */
// Types and constants for the timer table core.
// No dependencies; used by timer_table_one_shot_periodic_core.
`default_nettype none

package ttosp_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TIMER_SLOTS - 1);

    localparam int ID_W     = 31;
    localparam int NOW_W    = 47;
    localparam int DL_W     = 48;
    localparam int DELAY_W  = 32;
    localparam int MINPER_W = 16;
    localparam int CFG_W    = 31;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ID   = 1'b1;

    localparam logic [MINPER_W-1:0] MIN_PERIOD_RST = MINPER_W'(10);
    localparam logic [ID_W-1:0]     FIRST_ID_RST   = ID_W'(1);

    typedef enum logic [1:0] {
        OP_ADD_ONESHOT  = 2'd0,
        OP_ADD_PERIODIC = 2'd1,
        OP_CANCEL       = 2'd2,
        OP_TICK         = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        K_ADDED     = 3'd0,
        K_FULL      = 3'd1,
        K_CANCELLED = 3'd2,
        K_NOT_FOUND = 3'd3,
        K_FIRED     = 3'd4,
        K_NONE      = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_EMIT = 2'd2
    } state_t;

    typedef struct packed {
        op_t                       op;
        logic signed [DELAY_W-1:0] wait_ms;
        logic [ID_W-1:0]           target_id;
        logic [NOW_W-1:0]          now_ms;
    } in_item_t;

    typedef struct packed {
        kind_t           kind;
        logic [ID_W-1:0] result_id;
        logic            is_periodic;
        logic            last;
    } out_item_t;

endpackage

`default_nettype wire

/* design/timer_table_one_shot_periodic_core.sv */
// Timer table core: one-shot and periodic timers; needs ttosp_pkg and the defines header.
// Each request walks the slot table one slot per cycle through a single adder/compare unit;
// a tick holds on a due slot while a fired result waits and the output is stalled.
// Add and cancel stop at the first free or matching slot; a tick visits every slot.
// The result is loaded once the output is free; not ready while busy, one request at a time.
// Reset (aresetn low, synchronous): all slots free, min period 10, next identifier 1.
`default_nettype none

`include "timer_table_one_shot_periodic_core_defines.svh"

module timer_table_one_shot_periodic_core (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire ttosp_pkg::in_item_t                  s_data,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output ttosp_pkg::out_item_t                      m_data,
    input  wire logic                                 cfg_we,
    input  wire logic [ttosp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ttosp_pkg::CFG_W-1:0]          cfg_wdata
);

    ttosp_pkg::state_t                  state_reg, state_next;
    logic [ttosp_pkg::SLOT_W-1:0]       idx_reg, idx_next;
    ttosp_pkg::op_t                     op_reg;
    logic [ttosp_pkg::ID_W-1:0]         delay_reg;
    logic [ttosp_pkg::ID_W-1:0]         target_reg;
    logic [ttosp_pkg::NOW_W-1:0]        now_reg;
    logic [ttosp_pkg::MINPER_W-1:0]     min_period_reg;
    logic [ttosp_pkg::ID_W-1:0]         next_ident_reg;

    ttosp_pkg::out_item_t               res_reg, res_next;
    logic                               res_vld_reg, res_vld_next;
    logic                               m_valid_reg;
    ttosp_pkg::out_item_t               m_data_reg, out_next;
    logic                               out_load, out_free;

    logic [ttosp_pkg::TIMER_SLOTS-1:0]  used_reg;
    logic                               slot_periodic_reg [ttosp_pkg::TIMER_SLOTS];
    logic [ttosp_pkg::ID_W-1:0]         slot_ident_reg    [ttosp_pkg::TIMER_SLOTS];
    logic [ttosp_pkg::DL_W-1:0]         slot_deadline_reg [ttosp_pkg::TIMER_SLOTS];
    logic [ttosp_pkg::ID_W-1:0]         slot_period_reg   [ttosp_pkg::TIMER_SLOTS];

    logic                               accept;
    logic                               single_out;
    logic                               wr_alloc, wr_free, wr_resched, id_inc;
    logic                               is_add, is_last_slot, hit_free, hit_id, due;
    logic [ttosp_pkg::DL_W-1:0]         now_ext, sum;
    logic signed [ttosp_pkg::DELAY_W:0] d_ext, min_ext, d_clamp;
    logic [ttosp_pkg::ID_W-1:0]         delay_in;

    assign s_ready  = (state_reg == ttosp_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign single_out = m_valid && (m_data.kind != ttosp_pkg::K_FIRED);

    // delay clamp on entry: one-shot to >= 0, periodic to >= min period (signed)
    always_comb begin
        d_ext   = {s_data.wait_ms[ttosp_pkg::DELAY_W-1], s_data.wait_ms};
        min_ext = {{(ttosp_pkg::DELAY_W + 1 - ttosp_pkg::MINPER_W){1'b0}}, min_period_reg};
        if (s_data.op == ttosp_pkg::OP_ADD_PERIODIC) begin
            d_clamp = (d_ext < min_ext) ? min_ext : d_ext;
        end else begin
            d_clamp = d_ext[ttosp_pkg::DELAY_W] ? '0 : d_ext;
        end
        delay_in = d_clamp[ttosp_pkg::ID_W-1:0];
    end

    // shared slot unit: one adder and the compares against the current slot
    assign is_add       = (op_reg == ttosp_pkg::OP_ADD_ONESHOT) ||
                          (op_reg == ttosp_pkg::OP_ADD_PERIODIC);
    assign is_last_slot = (idx_reg == ttosp_pkg::LAST_SLOT);
    assign now_ext      = {1'b0, now_reg};
    assign sum          = now_ext + {{(ttosp_pkg::DL_W - ttosp_pkg::ID_W){1'b0}},
                                     (is_add ? delay_reg : slot_period_reg[idx_reg])};
    assign hit_free     = !used_reg[idx_reg];
    assign hit_id       = used_reg[idx_reg] && (slot_ident_reg[idx_reg] == target_reg);
    assign due          = used_reg[idx_reg] && !(now_ext < slot_deadline_reg[idx_reg]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ttosp_pkg::ST_IDLE;
            idx_reg     <= '0;
            res_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            res_vld_reg <= res_vld_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        if (out_load) begin
            m_data_reg <= out_next;
        end
        if (accept) begin
            op_reg     <= s_data.op;
            delay_reg  <= delay_in;
            target_reg <= s_data.target_id;
            now_reg    <= s_data.now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_period_reg <= ttosp_pkg::MIN_PERIOD_RST;
            next_ident_reg <= ttosp_pkg::FIRST_ID_RST;
        end else begin
            if (cfg_we && (cfg_index == ttosp_pkg::CFG_MIN_PERIOD)) begin
                min_period_reg <= cfg_wdata[ttosp_pkg::MINPER_W-1:0];
            end
            if (cfg_we && (cfg_index == ttosp_pkg::CFG_FIRST_ID)) begin
                next_ident_reg <= cfg_wdata[ttosp_pkg::ID_W-1:0];
            end else if (id_inc) begin
                next_ident_reg <= next_ident_reg + ttosp_pkg::ID_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else if (wr_alloc) begin
            used_reg[idx_reg] <= 1'b1;
        end else if (wr_free) begin
            used_reg[idx_reg] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_alloc) begin
            slot_periodic_reg[idx_reg] <= (op_reg == ttosp_pkg::OP_ADD_PERIODIC);
            slot_ident_reg[idx_reg]    <= next_ident_reg;
            slot_deadline_reg[idx_reg] <= sum;
            slot_period_reg[idx_reg]   <= (op_reg == ttosp_pkg::OP_ADD_PERIODIC) ?
                                          delay_reg : '0;
        end else if (wr_resched) begin
            slot_deadline_reg[idx_reg] <= sum;
        end
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        res_next     = res_reg;
        res_vld_next = res_vld_reg;
        out_load     = 1'b0;
        out_next     = res_reg;
        wr_alloc     = 1'b0;
        wr_free      = 1'b0;
        wr_resched   = 1'b0;
        id_inc       = 1'b0;
        unique case (state_reg)
            ttosp_pkg::ST_IDLE: begin
                idx_next = '0;
                if (accept) begin
                    res_vld_next = 1'b0;
                    state_next   = ttosp_pkg::ST_SCAN;
                end
            end
            ttosp_pkg::ST_SCAN: begin
                case (op_reg) inside
                    ttosp_pkg::OP_ADD_ONESHOT, ttosp_pkg::OP_ADD_PERIODIC: begin
                        if (hit_free) begin
                            wr_alloc     = 1'b1;
                            id_inc       = 1'b1;
                            res_next     = '{kind: ttosp_pkg::K_ADDED,
                                             result_id: next_ident_reg,
                                             is_periodic: 1'b0, last: 1'b1};
                            res_vld_next = 1'b1;
                            state_next   = ttosp_pkg::ST_EMIT;
                        end else if (is_last_slot) begin
                            res_next     = '{kind: ttosp_pkg::K_FULL, result_id: '0,
                                             is_periodic: 1'b0, last: 1'b1};
                            res_vld_next = 1'b1;
                            state_next   = ttosp_pkg::ST_EMIT;
                        end else begin
                            idx_next = idx_reg + ttosp_pkg::SLOT_W'(1);
                        end
                    end
                    ttosp_pkg::OP_CANCEL: begin
                        if (hit_id || is_last_slot) begin
                            wr_free      = hit_id;
                            res_next     = '{kind: (hit_id ? ttosp_pkg::K_CANCELLED
                                                           : ttosp_pkg::K_NOT_FOUND),
                                             result_id: target_reg,
                                             is_periodic: 1'b0, last: 1'b1};
                            res_vld_next = 1'b1;
                            state_next   = ttosp_pkg::ST_EMIT;
                        end else begin
                            idx_next = idx_reg + ttosp_pkg::SLOT_W'(1);
                        end
                    end
                    default: begin
                        // tick: hold back one fired result so the final one gets last
                        if (!(due && res_vld_reg && !out_free)) begin
                            if (due) begin
                                out_load     = res_vld_reg;
                                res_next     = '{kind: ttosp_pkg::K_FIRED,
                                                 result_id: slot_ident_reg[idx_reg],
                                                 is_periodic: slot_periodic_reg[idx_reg],
                                                 last: 1'b0};
                                res_vld_next = 1'b1;
                                wr_resched   = slot_periodic_reg[idx_reg];
                                wr_free      = !slot_periodic_reg[idx_reg];
                            end
                            if (is_last_slot) begin
                                state_next = ttosp_pkg::ST_EMIT;
                            end else begin
                                idx_next = idx_reg + ttosp_pkg::SLOT_W'(1);
                            end
                        end
                    end
                endcase
            end
            ttosp_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (res_vld_reg) begin
                        out_next      = res_reg;
                        out_next.last = 1'b1;
                    end else begin
                        out_next = '{kind: ttosp_pkg::K_NONE, result_id: '0,
                                     is_periodic: 1'b0, last: 1'b1};
                    end
                    idx_next   = '0;
                    state_next = ttosp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ttosp_pkg::ST_IDLE;
            end
        endcase
    end

    `TTOSP_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, accept, !s_ready, "ready after accept")
    `TTOSP_ASSERT_NOW(a_single_is_last, aclk, aresetn, single_out, m_data.last, "no last flag")
    `TTOSP_ASSERT_NOW(a_idle_idx_zero, aclk, aresetn, s_ready, idx_reg == '0, "index not cleared")

endmodule

`default_nettype wire

/* verif/tb_timer_checker.sv */
// Scoreboard for the timer table core: watches the request, result and register ports,
// predicts the results of each accepted request and compares them field by field.
// Depends on ttosp_pkg only.
`timescale 1ns / 100ps

module tb_timer_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    input  wire logic                            s_ready,
    input  wire ttosp_pkg::in_item_t             s_data,
    input  wire logic                            m_valid,
    input  wire logic                            m_ready,
    input  wire ttosp_pkg::out_item_t            m_data,
    input  wire logic                            cfg_we,
    input  wire logic [ttosp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ttosp_pkg::CFG_W-1:0]     cfg_wdata,
    output int                                   mismatches,
    output int                                   pending,
    output int                                   results_checked,
    output int                                   fired_seen,
    output int                                   full_seen,
    output int                                   cancel_seen
);

    logic                           tm_used     [ttosp_pkg::TIMER_SLOTS];
    logic                           tm_periodic [ttosp_pkg::TIMER_SLOTS];
    logic [ttosp_pkg::ID_W-1:0]     tm_ident    [ttosp_pkg::TIMER_SLOTS];
    logic [ttosp_pkg::DL_W-1:0]     tm_deadline [ttosp_pkg::TIMER_SLOTS];
    logic [ttosp_pkg::ID_W-1:0]     tm_period   [ttosp_pkg::TIMER_SLOTS];
    logic [ttosp_pkg::ID_W-1:0]     id_next;
    logic [ttosp_pkg::MINPER_W-1:0] min_period;
    ttosp_pkg::out_item_t           timer_replies [$];

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: mismatch in %s: want %0h got %0h", $time, what, want, got);
        mismatches++;
    endtask

    task automatic apply_timer_request(input ttosp_pkg::in_item_t rq);
        logic signed [ttosp_pkg::DELAY_W-1:0] span;
        logic [ttosp_pkg::ID_W-1:0]           span_ms;
        logic [ttosp_pkg::DL_W-1:0]           now48;
        ttosp_pkg::out_item_t                 r;
        ttosp_pkg::out_item_t                 held;
        bit                                   have_held;
        bit                                   done;
        int                                   slot;
        now48     = {1'b0, rq.now_ms};
        r         = '0;
        r.last    = 1'b1;
        held      = '0;
        have_held = 1'b0;
        done      = 1'b0;
        case (rq.op)
            ttosp_pkg::OP_ADD_ONESHOT, ttosp_pkg::OP_ADD_PERIODIC: begin
                span = rq.wait_ms;
                if (rq.op == ttosp_pkg::OP_ADD_PERIODIC) begin
                    if (span < $signed({{(ttosp_pkg::DELAY_W-ttosp_pkg::MINPER_W){1'b0}},
                                        min_period}))
                        span = $signed({{(ttosp_pkg::DELAY_W-ttosp_pkg::MINPER_W){1'b0}},
                                        min_period});
                end else if (span < 0) begin
                    span = '0;
                end
                span_ms = span[ttosp_pkg::ID_W-1:0];
                for (slot = 0; slot < ttosp_pkg::TIMER_SLOTS && !done; slot++) begin
                    if (!tm_used[slot]) begin
                        tm_used[slot]     = 1'b1;
                        tm_periodic[slot] = (rq.op == ttosp_pkg::OP_ADD_PERIODIC);
                        tm_ident[slot]    = id_next;
                        tm_deadline[slot] = now48 +
                            {{(ttosp_pkg::DL_W-ttosp_pkg::ID_W){1'b0}}, span_ms};
                        tm_period[slot]   = (rq.op == ttosp_pkg::OP_ADD_PERIODIC) ?
                                            span_ms : '0;
                        done              = 1'b1;
                    end
                end
                if (done) begin
                    r.kind      = ttosp_pkg::K_ADDED;
                    r.result_id = id_next;
                    id_next     = id_next + ttosp_pkg::ID_W'(1);
                end else begin
                    r.kind = ttosp_pkg::K_FULL;
                end
                timer_replies = {timer_replies, r};
            end
            ttosp_pkg::OP_CANCEL: begin
                for (slot = 0; slot < ttosp_pkg::TIMER_SLOTS && !done; slot++) begin
                    if (tm_used[slot] && tm_ident[slot] == rq.target_id) begin
                        tm_used[slot] = 1'b0;
                        done          = 1'b1;
                    end
                end
                r.kind      = done ? ttosp_pkg::K_CANCELLED : ttosp_pkg::K_NOT_FOUND;
                r.result_id = rq.target_id;
                timer_replies = {timer_replies, r};
            end
            default: begin
                for (slot = 0; slot < ttosp_pkg::TIMER_SLOTS; slot++) begin
                    if (tm_used[slot] && now48 >= tm_deadline[slot]) begin
                        if (have_held)
                            timer_replies = {timer_replies, held};
                        held             = '0;
                        held.kind        = ttosp_pkg::K_FIRED;
                        held.result_id   = tm_ident[slot];
                        held.is_periodic = tm_periodic[slot];
                        have_held        = 1'b1;
                        if (tm_periodic[slot])
                            tm_deadline[slot] = now48 +
                                {{(ttosp_pkg::DL_W-ttosp_pkg::ID_W){1'b0}}, tm_period[slot]};
                        else
                            tm_used[slot] = 1'b0;
                    end
                end
                if (have_held) begin
                    held.last = 1'b1;
                    timer_replies = {timer_replies, held};
                end else begin
                    r.kind = ttosp_pkg::K_NONE;
                    timer_replies = {timer_replies, r};
                end
            end
        endcase
    endtask

    task automatic check_timer_result(input ttosp_pkg::out_item_t got);
        ttosp_pkg::out_item_t want;
        if (timer_replies.size() == 0) begin
            report_mismatch("result with nothing awaited, kind", '0, 32'(got.kind));
        end else begin
            want = timer_replies.pop_front();
            results_checked++;
            if (got.kind !== want.kind)
                report_mismatch("kind", 32'(want.kind), 32'(got.kind));
            if (got.result_id !== want.result_id)
                report_mismatch("result_id", 32'(want.result_id), 32'(got.result_id));
            if (got.is_periodic !== want.is_periodic)
                report_mismatch("is_periodic", 32'(want.is_periodic), 32'(got.is_periodic));
            if (got.last !== want.last)
                report_mismatch("last", 32'(want.last), 32'(got.last));
            case (want.kind)
                ttosp_pkg::K_FIRED:     fired_seen++;
                ttosp_pkg::K_FULL:      full_seen++;
                ttosp_pkg::K_CANCELLED: cancel_seen++;
                default: ;
            endcase
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ttosp_pkg::TIMER_SLOTS; i++)
                tm_used[i] = 1'b0;
            min_period = ttosp_pkg::MIN_PERIOD_RST;
            id_next    = ttosp_pkg::FIRST_ID_RST;
            timer_replies.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == ttosp_pkg::CFG_MIN_PERIOD)
                    min_period = cfg_wdata[ttosp_pkg::MINPER_W-1:0];
                else if (cfg_index == ttosp_pkg::CFG_FIRST_ID)
                    id_next = cfg_wdata[ttosp_pkg::ID_W-1:0];
            end
            if (m_valid && m_ready)
                check_timer_result(m_data);
            if (s_valid && s_ready)
                apply_timer_request(s_data);
        end
        pending = timer_replies.size();
    end

endmodule

/* verif/tb_top.sv */
// Testbench top for the timer table core: clock, reset, requests, register writes and verdict.
// Instantiates timer_table_one_shot_periodic_core and tb_timer_checker; depends on ttosp_pkg.
`timescale 1ns / 100ps

module tb_top;

    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_CYCLES = 2 * ttosp_pkg::TIMER_SLOTS + 8;
    localparam int RUN_LIMIT_NS = 2_000_000;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    ttosp_pkg::in_item_t             s_data;
    logic                            m_valid;
    logic                            m_ready;
    ttosp_pkg::out_item_t            m_data;
    logic                            cfg_we;
    logic [ttosp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ttosp_pkg::CFG_W-1:0]     cfg_wdata;

    int mismatches, pending, results_checked, fired_seen, full_seen, cancel_seen;
    int requests_sent;
    int settings_used;
    bit quiet;
    bit hold_off;
    bit hold_done;

    logic [ttosp_pkg::NOW_W-1:0] clock_ms;
    logic [ttosp_pkg::ID_W-1:0]  phase_first_id;
    logic [ttosp_pkg::ID_W-1:0]  live_ids [$];

    timer_table_one_shot_periodic_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    tb_timer_checker chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked),
        .fired_seen      (fired_seen),
        .full_seen       (full_seen),
        .cancel_seen     (cancel_seen)
    );

    always #2 aclk = ~aclk;

    initial begin
        #RUN_LIMIT_NS;
        $display("TB_ERROR");
        $finish;
    end

    // ids believed live, used to aim cancel requests
    task automatic drop_live_id(input logic [ttosp_pkg::ID_W-1:0] id);
        int i;
        for (i = 0; i < live_ids.size(); i++) begin
            if (live_ids[i] == id) begin
                live_ids.delete(i);
                break;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            case (m_data.kind)
                ttosp_pkg::K_ADDED:     live_ids = {live_ids, m_data.result_id};
                ttosp_pkg::K_CANCELLED: drop_live_id(m_data.result_id);
                ttosp_pkg::K_FIRED:     if (!m_data.is_periodic) drop_live_id(m_data.result_id);
                default: ;
            endcase
        end
    end

    // result side: short random stalls, one long hold-off on request
    initial begin
        m_ready   = 1'b1;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 99) < 20) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge aclk);
                @(negedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_req(input ttosp_pkg::op_t op,
                            input logic [ttosp_pkg::DELAY_W-1:0] dly,
                            input logic [ttosp_pkg::ID_W-1:0] tgt,
                            input logic [ttosp_pkg::NOW_W-1:0] at_ms);
        ttosp_pkg::in_item_t rq;
        rq.op        = op;
        rq.wait_ms   = dly;
        rq.target_id = tgt;
        rq.now_ms    = at_ms;
        if (!quiet && $urandom_range(0, 99) < 20) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= rq;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (QUIET_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [ttosp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ttosp_pkg::CFG_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_registers(input logic [ttosp_pkg::CFG_W-1:0] min_word,
                                 input logic [ttosp_pkg::ID_W-1:0] first);
        write_reg(ttosp_pkg::CFG_MIN_PERIOD, min_word);
        write_reg(ttosp_pkg::CFG_FIRST_ID, first);
        phase_first_id = first;
        settings_used++;
    endtask

    task automatic random_burst(input int count);
        int                                n;
        int                                roll;
        ttosp_pkg::op_t                    op;
        logic [ttosp_pkg::DELAY_W-1:0]     dly;
        logic [ttosp_pkg::ID_W-1:0]        tgt;
        for (n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                clock_ms = clock_ms - ttosp_pkg::NOW_W'($urandom_range(1, 200));
            else
                clock_ms = clock_ms + ttosp_pkg::NOW_W'($urandom_range(0, 25));
            roll = $urandom_range(0, 99);
            if (roll < 28)
                op = ttosp_pkg::OP_ADD_ONESHOT;
            else if (roll < 45)
                op = ttosp_pkg::OP_ADD_PERIODIC;
            else if (roll < 67)
                op = ttosp_pkg::OP_CANCEL;
            else
                op = ttosp_pkg::OP_TICK;
            roll = $urandom_range(0, 99);
            if (roll < 70)
                dly = ttosp_pkg::DELAY_W'($urandom_range(0, 80));
            else if (roll < 82)
                dly = -ttosp_pkg::DELAY_W'($urandom_range(1, 60));
            else
                dly = $urandom;
            if (live_ids.size() != 0 && $urandom_range(0, 99) < 80)
                tgt = live_ids[$urandom_range(0, live_ids.size() - 1)];
            else
                tgt = ttosp_pkg::ID_W'($urandom);
            send_req(op, dly, tgt, clock_ms);
        end
    endtask

    initial begin
        int k;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        cfg_we         = 1'b0;
        cfg_index      = ttosp_pkg::CFG_MIN_PERIOD;
        cfg_wdata      = '0;
        quiet          = 1'b0;
        hold_off       = 1'b0;
        requests_sent  = 0;
        settings_used  = 1;
        clock_ms       = '0;
        phase_first_id = ttosp_pkg::FIRST_ID_RST;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings, min period 10, first id 1
        send_req(ttosp_pkg::OP_TICK, '0, '0, '0);
        send_req(ttosp_pkg::OP_CANCEL, '0, '1, '0);
        send_req(ttosp_pkg::OP_ADD_ONESHOT, 32'h8000_0000, '0, 47'd100);
        send_req(ttosp_pkg::OP_ADD_ONESHOT, 32'h0000_0000, '0, 47'd100);
        send_req(ttosp_pkg::OP_ADD_ONESHOT, 32'h7FFF_FFFF, '0, 47'd100);
        send_req(ttosp_pkg::OP_ADD_PERIODIC, 32'h8000_0000, '0, 47'd100);
        send_req(ttosp_pkg::OP_ADD_PERIODIC, 32'd3, '0, 47'd100);
        send_req(ttosp_pkg::OP_ADD_PERIODIC, 32'h7FFF_FFFF, '0, 47'd100);
        send_req(ttosp_pkg::OP_ADD_PERIODIC, 32'd40, '0, 47'd100);
        for (k = 0; k < 9; k++)
            send_req((k == 4) ? ttosp_pkg::OP_ADD_PERIODIC : ttosp_pkg::OP_ADD_ONESHOT,
                     ttosp_pkg::DELAY_W'($urandom_range(0, 60)),
                     ttosp_pkg::ID_W'($urandom), 47'd100);
        send_req(ttosp_pkg::OP_ADD_ONESHOT, 32'd5, '0, 47'd100);
        send_req(ttosp_pkg::OP_TICK, $urandom, ttosp_pkg::ID_W'($urandom), '1);
        send_req(ttosp_pkg::OP_TICK, '0, '0, 47'd150);
        send_req(ttosp_pkg::OP_CANCEL, '0, 31'd4, 47'd150);
        send_req(ttosp_pkg::OP_CANCEL, '0, 31'd1, 47'd150);
        settle();

        set_registers('0, 31'h7FFF_FFFD);
        clock_ms = 47'd1000;
        random_burst(55);
        settle();

        set_registers(31'h0000_FFFF, '0);
        clock_ms = ttosp_pkg::NOW_W'({$urandom, $urandom});
        random_burst(45);
        settle();

        set_registers(ttosp_pkg::CFG_W'($urandom_range(1, 30)), ttosp_pkg::ID_W'($urandom));
        clock_ms = 47'h7FFF_FFFF_FF00;
        random_burst(20);
        hold_off = 1'b1;
        random_burst(35);
        settle();

        // reuse the previous first id so duplicates meet the cancel scan
        set_registers(31'd5, phase_first_id);
        clock_ms = ttosp_pkg::NOW_W'({$urandom, $urandom});
        random_burst(25);
        settle();
        random_burst(30);
        settle();

        quiet = 1'b1;
        set_registers(ttosp_pkg::CFG_W'($urandom), ttosp_pkg::ID_W'($urandom));
        random_burst(45);
        settle();

        $display("Covered %0d requests over %0d register settings, %0d results checked.",
                 requests_sent, settings_used, results_checked);
        $display("Timers fired: %0d, table-full answers: %0d, cancels that hit: %0d.",
                 fired_seen, full_seen, cancel_seen);
        if (mismatches == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
